// ----- rtl/implicit_tree_node_depth_search_macros.svh -----
// Assertion macros for the checker file itnds_check.sv.
`ifndef IMPLICIT_TREE_NODE_DEPTH_SEARCH_MACROS_SVH
`define IMPLICIT_TREE_NODE_DEPTH_SEARCH_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ITNDS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itnds check failed");

// Next-cycle implication, ignored while reset is high.
`define ITNDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itnds check failed");

// Next-cycle implication that also holds across reset.
`define ITNDS_ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("itnds check failed");

`endif

// ----- rtl/itnds_pkg.sv -----
`default_nettype none

package itnds_pkg;

  localparam int CMD_W   = 1;
  localparam int SLOT_W  = 5;
  localparam int SYM_W   = 8;
  localparam int DEPTH_W = 5;
  localparam int MAXD_W  = 4;
  // Level counter width, enough for the deepest tree the block supports
  localparam int LVL_W   = 4;

  localparam logic [SYM_W-1:0]   EMPTY_MARK = 8'd45;
  localparam logic [MAXD_W-1:0]  MAXD_RESET = 4'd4;
  localparam logic [DEPTH_W-1:0] DEPTH_NONE = 5'h1F;

  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    NAV_LEFT,
    NAV_SIB,
    NAV_UP
  } nav_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CHECK,
    ST_CLIMB,
    ST_PUT
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/itnds_in_if.sv -----
`default_nettype none

interface itnds_in_if;
  import itnds_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SLOT_W-1:0] slot;
  logic [SYM_W-1:0]  symbol;

  modport source (output valid, output cmd, output slot, output symbol, input ready);
  modport sink   (input valid, input cmd, input slot, input symbol, output ready);
endinterface

`default_nettype wire

// ----- rtl/itnds_out_if.sv -----
`default_nettype none

interface itnds_out_if;
  import itnds_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DEPTH_W-1:0] depth;

  modport source (output valid, output depth, input ready);
  modport sink   (input valid, input depth, output ready);
endinterface

`default_nettype wire

// ----- rtl/itnds_store.sv -----
`default_nettype none

module itnds_store #(
  parameter int LEVELS = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr_en,
  input  wire logic [LEVELS-1:0]           wr_addr,
  input  wire logic [itnds_pkg::SYM_W-1:0] wr_data,
  input  wire logic [LEVELS-1:0]           rd_addr,
  output logic      [itnds_pkg::SYM_W-1:0] rd_data,
  output logic                             ready
);
  import itnds_pkg::*;

  localparam int NODES = (1 << LEVELS) - 1;
  localparam logic [LEVELS-1:0] LAST = LEVELS'(NODES - 1);

  logic [SYM_W-1:0]  mem [NODES];
  logic              clearing;
  logic [LEVELS-1:0] clr_idx;

  // Sweep the whole store with the empty marker after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // Write port: clearing pass has priority
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= EMPTY_MARK;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  assign ready = !clearing;

endmodule

`default_nettype wire

// ----- rtl/itnds_nav.sv -----
`default_nettype none

module itnds_nav #(
  parameter int LEVELS = 5
) (
  input  wire itnds_pkg::nav_op_t          op,
  input  wire logic [LEVELS-1:0]           idx,
  input  wire logic [itnds_pkg::LVL_W-1:0] lvl,
  output logic      [LEVELS-1:0]           nxt_idx,
  output logic      [itnds_pkg::LVL_W-1:0] nxt_lvl,
  output logic                             is_right
);
  import itnds_pkg::*;

  localparam logic [LVL_W-1:0] TOP_K = LVL_W'(LEVELS - 1);

  logic [LVL_W-1:0]  k;
  logic [LEVELS-1:0] pw;
  logic [LEVELS-1:0] operand;
  logic              sub;
  logic [LEVELS-1:0] pos;

  // Half-span of the node's subtree: 2^(LEVELS-1-lvl)
  assign k  = TOP_K - lvl;
  assign pw = LEVELS'(1) << k;

  // One adder serves every move: down-left, across to sibling, up to parent
  always_comb begin
    unique case (op)
      NAV_LEFT: begin
        operand = pw >> 1;
        sub     = 1'b1;
        nxt_lvl = lvl + 1'b1;
      end
      NAV_SIB: begin
        operand = pw << 1;
        sub     = 1'b0;
        nxt_lvl = lvl;
      end
      NAV_UP: begin
        operand = pw;
        sub     = 1'b1;
        nxt_lvl = lvl - 1'b1;
      end
      default: begin
        operand = '0;
        sub     = 1'b0;
        nxt_lvl = lvl;
      end
    endcase
  end

  assign nxt_idx = sub ? (idx - operand) : (idx + operand);

  // A right child has bit k+1 of (idx+1) set
  assign pos      = idx + 1'b1;
  assign is_right = |(pos & (pw << 1));

endmodule

`default_nettype wire

// ----- rtl/implicit_tree_node_depth_search.sv -----
// Channel | Dir | Word                        | Moves on
// req     | in  | cmd, slot, symbol           | valid & ready
// rsp     | out | depth (signed, -1 = none)   | valid & ready
// cfg     | in  | max_depth                   | cfg_we
//
// A write goes straight into the store. A query holds the input while it walks
// the tree on the single store read port: each visited node is read (ST_FETCH),
// then compared (ST_CHECK), each level climbed back is a ST_CLIMB step, and
// ST_PUT hands the word over.
// After reset the store is swept with the empty marker, with req.ready low.
// A finished depth waits in the output register; a new word is taken while it
// waits, a second query stalls at the end.
`default_nettype none

module implicit_tree_node_depth_search #(
  parameter int LEVELS = 5
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  itnds_in_if.sink                          req,
  itnds_out_if.source                       rsp,
  input  wire logic                         cfg_we,
  input  wire logic [itnds_pkg::MAXD_W-1:0] cfg_wdata
);
  import itnds_pkg::*;

  localparam int NODES = (1 << LEVELS) - 1;
  localparam logic [LEVELS-1:0] ROOT    = LEVELS'((NODES - 1) / 2);
  localparam logic [LVL_W-1:0]  LEAF_LV = LVL_W'(LEVELS - 1);
  localparam logic [LVL_W-1:0]  LV_ONE  = LVL_W'(1);

  state_t            state;
  state_t            state_next;
  logic [LEVELS-1:0] idx;
  logic [LEVELS-1:0] idx_next;
  logic [LVL_W-1:0]  lvl;
  logic [LVL_W-1:0]  lvl_next;
  logic [SYM_W-1:0]  key;
  logic signed [DEPTH_W-1:0] best;
  logic signed [DEPTH_W-1:0] best_next;
  logic [MAXD_W-1:0] max_depth;
  logic              out_valid;
  logic signed [DEPTH_W-1:0] out_depth;

  logic              accept;
  logic              wr_en;
  logic              store_ready;
  logic [SYM_W-1:0]  rd_data;
  nav_op_t           nav_op;
  logic [LEVELS-1:0] nav_idx;
  logic [LVL_W-1:0]  nav_lvl;
  logic              nav_right;
  logic              load_out;
  logic              empty;
  logic              hit;
  logic              expand;

  itnds_store #(.LEVELS(LEVELS)) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (LEVELS'(req.slot)),
    .wr_data (req.symbol),
    .rd_addr (idx),
    .rd_data (rd_data),
    .ready   (store_ready)
  );

  itnds_nav #(.LEVELS(LEVELS)) u_nav (
    .op       (nav_op),
    .idx      (idx),
    .lvl      (lvl),
    .nxt_idx  (nav_idx),
    .nxt_lvl  (nav_lvl),
    .is_right (nav_right)
  );

  assign req.ready = (state == ST_IDLE) && store_ready;
  assign accept    = req.valid && req.ready;
  assign wr_en     = accept && (req.cmd == CMD_WRITE) && (int'(req.slot) < NODES);

  // Node tests on the word just read
  assign empty  = (rd_data == EMPTY_MARK);
  assign hit    = !empty && (rd_data == key);
  assign expand = !empty && !hit && (lvl < LEAF_LV) && (lvl < max_depth);

  // Sequencer: depth-first walk, at most one move of the shared adder per step
  always_comb begin
    state_next = state;
    idx_next   = idx;
    lvl_next   = lvl;
    best_next  = best;
    nav_op     = NAV_LEFT;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && (req.cmd == CMD_QUERY)) begin
          idx_next   = ROOT;
          lvl_next   = '0;
          best_next  = DEPTH_NONE;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_CHECK;
      end
      ST_CHECK, ST_CLIMB: begin
        if ((state == ST_CHECK) && (lvl == '0)) begin
          // Root: empty or equal answers zero, else descend if allowed
          if (empty || (rd_data == key)) begin
            best_next  = '0;
            state_next = ST_PUT;
          end else if (max_depth == '0) begin
            state_next = ST_PUT;
          end else begin
            nav_op     = NAV_LEFT;
            idx_next   = nav_idx;
            lvl_next   = nav_lvl;
            state_next = ST_FETCH;
          end
        end else if ((state == ST_CHECK) && expand) begin
          nav_op     = NAV_LEFT;
          idx_next   = nav_idx;
          lvl_next   = nav_lvl;
          state_next = ST_FETCH;
        end else if (nav_right) begin
          // Subtree done; climb while on a right branch
          if (lvl == LV_ONE) begin
            state_next = ST_PUT;
          end else begin
            nav_op     = NAV_UP;
            idx_next   = nav_idx;
            lvl_next   = nav_lvl;
            state_next = ST_CLIMB;
          end
        end else begin
          nav_op     = NAV_SIB;
          idx_next   = nav_idx;
          lvl_next   = nav_lvl;
          state_next = ST_FETCH;
        end
        // Keep the deepest match
        if ((state == ST_CHECK) && (lvl != '0) && hit &&
            ($signed({1'b0, lvl}) > best)) begin
          best_next = $signed({1'b0, lvl});
        end
      end
      ST_PUT: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      max_depth <= MAXD_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        max_depth <= cfg_wdata;
      end
    end
  end

  // Walk position and running result
  always_ff @(posedge clk) begin
    idx  <= idx_next;
    lvl  <= lvl_next;
    best <= best_next;
    if (accept) begin
      key <= req.symbol;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_depth <= best;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.depth = out_depth;

endmodule

`default_nettype wire

// ----- rtl/itnds_check.sv -----
`default_nettype none

`include "implicit_tree_node_depth_search_macros.svh"

module itnds_check (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          req_valid,
  input wire logic                          req_ready,
  input wire logic [itnds_pkg::CMD_W-1:0]   req_cmd,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [itnds_pkg::DEPTH_W-1:0] rsp_depth
);
  import itnds_pkg::*;

  logic query_taken;
  logic depth_ok;

  assign query_taken = req_valid && req_ready && (req_cmd == CMD_QUERY);
  assign depth_ok    = !rsp_depth[DEPTH_W-1] || (rsp_depth == DEPTH_NONE);

  // Store sweep keeps the input closed right after reset
  `ITNDS_ASSERT_NEXT_ANY(a_reset_busy, clk, rst, !req_ready)

  // A query word closes the input while the walk runs
  `ITNDS_ASSERT_NEXT(a_query_busy, clk, rst, query_taken, !req_ready)

  // Depth is never below minus one
  `ITNDS_ASSERT_NOW(a_depth_range, clk, rst, rsp_valid, depth_ok)

  // A stalled result holds
  `ITNDS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_depth))

endmodule

bind implicit_tree_node_depth_search itnds_check u_itnds_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_cmd   (req.cmd),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_depth (rsp.depth)
);

`default_nettype wire
